@@ hdl/sbsq_pkg.sv @@
`timescale 1ns / 1ps

package sbsq_pkg;

	// Sizing
	localparam int MAX_SLOTS  = 16;
	localparam int ID_BITS    = 16;
	localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

	// Fixed field widths
	localparam int FUNC_W     = 3;
	localparam int IDX_W      = 4;
	localparam int SIZE_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Common width for comparing slot numbers, sizes and request indexes
	localparam int CMP_W      = CNT_W + IDX_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GROW_MODE  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_CRIPPLED   = CFG_IDX_W'(2);

	localparam logic [CFG_DATA_W-1:0] SLOT_COUNT_RST = CFG_DATA_W'(16);

	// Event codes
	typedef enum logic [FUNC_W-1:0] {
		FN_RESERVE = 3'd0,
		FN_ADVANCE = 3'd1,
		FN_REACHED = 3'd2,
		FN_ENTER   = 3'd3,
		FN_EXIT    = 3'd4,
		FN_CANCEL  = 3'd5,
		FN_TICK    = 3'd6,
		FN_QUERY   = 3'd7
	} func_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [ID_BITS-1:0] requester_id;
		logic [IDX_W-1:0]   slot_index;
	} cmd_beat_t;

	typedef struct packed {
		logic               ok;
		logic [IDX_W-1:0]   granted_slot;
		logic               clear_to_approach;
		logic               clear_to_enter;
		logic               clear_to_advance;
		logic [ID_BITS-1:0] active_client;
		logic               client_inside;
		logic [SIZE_W-1:0]  slots_used;
	} rsp_beat_t;

	// Controller to datapath
	typedef struct packed {
		logic              load;
		logic              scan;
		logic [SLOT_W-1:0] addr;
		logic              apply_a;
		logic              apply_b;
		logic              finish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// Slot count as used by the table: 0 reads as 1, large values saturate
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = CNT_W'(1);
		else if (int'(v) > MAX_SLOTS)
			r = CNT_W'(MAX_SLOTS);
		else
			r = CNT_W'(v);
		return r;
	endfunction

endpackage

@@ hdl/sbsq_ifs.sv @@
`timescale 1ns / 1ps

// Event channel
interface sbsq_cmd_if;
	logic                 valid;
	logic                 ready;
	sbsq_pkg::cmd_beat_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// Result channel
interface sbsq_rsp_if;
	logic                 valid;
	logic                 ready;
	sbsq_pkg::rsp_beat_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sbsq_ctrl.sv @@
`timescale 1ns / 1ps

module sbsq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  sbsq_pkg::dp_status_t  status,
	output sbsq_pkg::dp_cmd_t     dp_cmd
);
	import sbsq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY_A,
		ST_APPLY_B,
		ST_FINISH
	} state_t;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

	state_t            state_q;
	logic [SLOT_W-1:0] addr_q;

	// Sequencer: one pass over every slot, two write-back steps, result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (cmd_valid)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					addr_q <= addr_q + SLOT_W'(1);
					if (addr_q == LAST_SLOT)
						state_q <= ST_APPLY_A;
				end
				ST_APPLY_A: state_q <= ST_APPLY_B;
				ST_APPLY_B: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (status.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Commands decoded from state
	always_comb begin
		cmd_ready      = (state_q == ST_IDLE);
		dp_cmd.load    = (state_q == ST_IDLE) && cmd_valid;
		dp_cmd.scan    = (state_q == ST_SCAN);
		dp_cmd.addr    = addr_q;
		dp_cmd.apply_a = (state_q == ST_APPLY_A);
		dp_cmd.apply_b = (state_q == ST_APPLY_B);
		dp_cmd.finish  = (state_q == ST_FINISH) && status.out_free;
	end

endmodule

@@ hdl/sbsq_dp.sv @@
`timescale 1ns / 1ps

module sbsq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sbsq_pkg::dp_cmd_t                   dp_cmd,
	output sbsq_pkg::dp_status_t                status,
	input  sbsq_pkg::cmd_beat_t                 cmd_data,
	input  logic                                cfg_we,
	input  logic [sbsq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sbsq_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output sbsq_pkg::rsp_beat_t                 rsp_data
);
	import sbsq_pkg::*;

	// Slot table
	logic [ID_BITS-1:0]    owner_q   [MAX_SLOTS];
	logic                  reached_q [MAX_SLOTS];

	// Bay state and configuration
	logic [ID_BITS-1:0]    active_q;
	logic                  inside_q;
	logic [CNT_W-1:0]      size_q;
	logic [CFG_DATA_W-1:0] count_cfg_q;
	logic                  grow_q;
	logic                  crip_q;

	// Current event
	func_t                 func_q;
	logic [ID_BITS-1:0]    req_q;
	logic [IDX_W-1:0]      idx_q;

	// Scan findings
	logic                  hit_found_q;
	logic [SLOT_W-1:0]     hit_idx_q;
	logic                  own_found_q;
	logic [SLOT_W-1:0]     own_idx_q;
	logic                  rch_found_q;
	logic [ID_BITS-1:0]    rch_owner_q;

	// Copies of slot idx and slot idx-1, kept current through the write-back
	logic [ID_BITS-1:0]    cap_own_q;
	logic                  cap_rch_q;
	logic [ID_BITS-1:0]    cap_prev_q;

	logic                  ok_q;
	logic [SLOT_W-1:0]     gslot_q;

	logic                  rsp_valid_q;
	rsp_beat_t             rsp_q;

	// Scan read
	logic [ID_BITS-1:0]    scan_own;
	logic                  scan_rch;
	logic                  in_tbl;
	logic                  cancel_hit;
	logic [ID_BITS-1:0]    scan_own_new;
	logic                  scan_rch_new;

	// Write port
	logic                  we_own;
	logic                  we_rch;
	logic [SLOT_W-1:0]     waddr;
	logic [ID_BITS-1:0]    wown;
	logic                  wrch;

	logic                  adv_ok;
	logic                  can_grow;
	logic                  grow_hit;
	logic                  adv_post;

	assign scan_own     = owner_q[dp_cmd.addr];
	assign scan_rch     = reached_q[dp_cmd.addr];
	assign in_tbl       = CMP_W'(dp_cmd.addr) < CMP_W'(size_q);
	assign cancel_hit   = (func_q == FN_CANCEL) && in_tbl && (scan_own == req_q);
	assign scan_own_new = cancel_hit ? '0 : scan_own;
	assign scan_rch_new = cancel_hit ? 1'b0 : scan_rch;

	assign adv_ok   = (idx_q != '0) && (CMP_W'(idx_q) < CMP_W'(size_q)) && (cap_prev_q == '0);
	assign can_grow = grow_q && (CMP_W'(size_q) < CMP_W'(MAX_SLOTS));
	assign grow_hit = !hit_found_q && can_grow;

	// Slot write selection
	always_comb begin
		we_own = 1'b0;
		we_rch = 1'b0;
		waddr  = dp_cmd.addr;
		wown   = '0;
		wrch   = 1'b0;
		if (dp_cmd.scan) begin
			we_own = cancel_hit;
			we_rch = cancel_hit;
		end else if (dp_cmd.apply_a) begin
			case (func_q)
				FN_RESERVE: begin
					if (hit_found_q) begin
						we_own = 1'b1;
						waddr  = hit_idx_q;
						wown   = req_q;
					end else if (can_grow) begin
						we_own = 1'b1;
						we_rch = 1'b1;
						waddr  = SLOT_W'(size_q);
						wown   = req_q;
					end
				end
				FN_ADVANCE: begin
					we_own = adv_ok;
					we_rch = adv_ok;
					waddr  = SLOT_W'(idx_q - IDX_W'(1));
					wown   = req_q;
				end
				FN_REACHED: begin
					we_rch = own_found_q;
					waddr  = own_idx_q;
					wrch   = 1'b1;
				end
				FN_ENTER: begin
					we_own = own_found_q;
					we_rch = own_found_q;
					waddr  = own_idx_q;
				end
				default: ;
			endcase
		end else if (dp_cmd.apply_b) begin
			// second half of an advance: vacate the old slot
			we_own = (func_q == FN_ADVANCE) && ok_q;
			we_rch = (func_q == FN_ADVANCE) && ok_q;
			waddr  = SLOT_W'(idx_q);
		end
	end

	// Advance query on the state after the event
	assign adv_post = (idx_q != '0) && (CMP_W'(idx_q) < CMP_W'(size_q))
		&& (cap_own_q == req_q) && cap_rch_q && (cap_prev_q == '0);

	assign status.out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				owner_q[i]   <= '0;
				reached_q[i] <= 1'b0;
			end
			active_q    <= '0;
			inside_q    <= 1'b0;
			count_cfg_q <= SLOT_COUNT_RST;
			size_q      <= clamp_count(SLOT_COUNT_RST);
			grow_q      <= 1'b0;
			crip_q      <= 1'b0;
			func_q      <= FN_QUERY;
			req_q       <= '0;
			idx_q       <= '0;
			hit_found_q <= 1'b0;
			hit_idx_q   <= '0;
			own_found_q <= 1'b0;
			own_idx_q   <= '0;
			rch_found_q <= 1'b0;
			rch_owner_q <= '0;
			cap_own_q   <= '0;
			cap_rch_q   <= 1'b0;
			cap_prev_q  <= '0;
			ok_q        <= 1'b0;
			gslot_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_SLOT_COUNT: begin
						count_cfg_q <= cfg_data;
						size_q      <= clamp_count(cfg_data);
					end
					CFG_GROW_MODE: begin
						grow_q <= cfg_data[0];
						size_q <= clamp_count(count_cfg_q);
					end
					CFG_CRIPPLED: crip_q <= cfg_data[0];
					default: ;
				endcase
			end

			// take a new event
			if (dp_cmd.load) begin
				func_q      <= func_t'(cmd_data.func);
				req_q       <= cmd_data.requester_id;
				idx_q       <= cmd_data.slot_index;
				hit_found_q <= 1'b0;
				own_found_q <= 1'b0;
				rch_found_q <= 1'b0;
				ok_q        <= 1'b0;
				gslot_q     <= '0;
			end

			// scan: first free-or-own, first own, first reached, copies
			if (dp_cmd.scan) begin
				if (in_tbl && !hit_found_q && (scan_own == req_q || scan_own == '0)) begin
					hit_found_q <= 1'b1;
					hit_idx_q   <= dp_cmd.addr;
				end
				if (in_tbl && !own_found_q && scan_own == req_q) begin
					own_found_q <= 1'b1;
					own_idx_q   <= dp_cmd.addr;
				end
				if (in_tbl && !rch_found_q && scan_rch) begin
					rch_found_q <= 1'b1;
					rch_owner_q <= scan_own;
				end
				if (CMP_W'(dp_cmd.addr) == CMP_W'(idx_q)) begin
					cap_own_q <= scan_own_new;
					cap_rch_q <= scan_rch_new;
				end
				if (CMP_W'(dp_cmd.addr) + CMP_W'(1) == CMP_W'(idx_q))
					cap_prev_q <= scan_own_new;
			end else begin
				// keep the copies in step with write-back
				if (we_own && CMP_W'(waddr) == CMP_W'(idx_q))
					cap_own_q <= wown;
				if (we_rch && CMP_W'(waddr) == CMP_W'(idx_q))
					cap_rch_q <= wrch;
				if (we_own && CMP_W'(waddr) + CMP_W'(1) == CMP_W'(idx_q))
					cap_prev_q <= wown;
			end

			// slot table write port
			if (we_own)
				owner_q[waddr] <= wown;
			if (we_rch)
				reached_q[waddr] <= wrch;

			// event effects outside the slot table
			if (dp_cmd.apply_a) begin
				case (func_q)
					FN_RESERVE: begin
						if (hit_found_q) begin
							ok_q    <= 1'b1;
							gslot_q <= hit_idx_q;
						end else if (grow_hit) begin
							ok_q    <= 1'b1;
							gslot_q <= SLOT_W'(size_q);
							size_q  <= size_q + CNT_W'(1);
						end
					end
					FN_ADVANCE: begin
						if (adv_ok) begin
							ok_q    <= 1'b1;
							gslot_q <= SLOT_W'(idx_q - IDX_W'(1));
						end
					end
					FN_ENTER: inside_q <= 1'b1;
					FN_EXIT: begin
						inside_q <= 1'b0;
						if (active_q == req_q)
							active_q <= '0;
					end
					FN_CANCEL: begin
						if (active_q == req_q) begin
							active_q <= '0;
							inside_q <= 1'b0;
						end
					end
					FN_TICK: begin
						if (active_q == '0 && !crip_q && rch_found_q)
							active_q <= rch_owner_q;
					end
					default: ;
				endcase
			end

			// result register
			if (dp_cmd.finish) begin
				rsp_valid_q             <= 1'b1;
				rsp_q.ok                <= ok_q;
				rsp_q.granted_slot      <= IDX_W'(gslot_q);
				rsp_q.clear_to_approach <= grow_q || hit_found_q;
				rsp_q.clear_to_enter    <= (req_q == active_q);
				rsp_q.clear_to_advance  <= adv_post;
				rsp_q.active_client     <= active_q;
				rsp_q.client_inside     <= inside_q;
				rsp_q.slots_used        <= SIZE_W'(size_q);
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

@@ hdl/service_bay_slot_queue_top.sv @@
`timescale 1ns / 1ps

// Service bay slot queue.
// Events arrive as beats on cmd (func, requester_id, slot_index) and each
// produces exactly one result beat on rsp, in order. Both channels use a
// valid/ready handshake; a beat moves on a clock edge with both high.
// Each event runs from its accepting edge to a valid result as a pass that
// reads one slot of the table per cycle over every slot, two write-back
// steps and a load of the result register. The pass is paced by the single
// read port of the slot table; a new event is taken in the cycle after the
// result loads, so the block does not take a new event before it has
// finished the last one.
// The result register decouples the sides: a result may wait on rsp while
// the next event is accepted and processed; a stalled receiver only holds
// the finished event in its load cycle until the register frees up.
// Configuration (slot_count, grow_mode, crippled) is a plain write port,
// written only while the block is idle by the user; the block does not
// enforce it. Writing slot_count or grow_mode reloads the table size.
// Reset (arst_n low) frees all slots, drops the grant and the inside flag,
// and restores slot_count 16, grow_mode 0 and crippled 0.
module service_bay_slot_queue_top (
	input  logic                               clk,
	input  logic                               arst_n,
	sbsq_cmd_if.sink                           cmd,
	sbsq_rsp_if.source                         rsp,
	input  logic                               cfg_we,
	input  logic [sbsq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sbsq_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import sbsq_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t status;
	logic       cmd_ready;
	logic       rsp_valid;
	rsp_beat_t  rsp_data;

	sbsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd_ready),
		.status    (status),
		.dp_cmd    (dp_cmd)
	);

	sbsq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.status    (status),
		.cmd_data  (cmd.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp_data)
	);

	assign cmd.ready = cmd_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

endmodule
